// ----- rtl/tpg_pkg.sv -----
// Shared constants and widths for the two-path grid maximum-sum block.
`default_nettype none

package tpg_pkg;

    // Default sizing of the grid and its cells
    localparam int MAX_ROWS_DEF   = 64;
    localparam int MAX_COLS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 8;

    // Fixed field widths on the channels and the configuration port
    localparam int CELL_BITS      = 8;
    localparam int SUM_OUT_BITS   = 17;
    localparam int COUNT_BITS     = 7;
    localparam int CFG_INDEX_BITS = 1;

    // Saturation limit of the reported sum
    localparam logic [SUM_OUT_BITS-1:0] SUM_OUT_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_COUNT = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COL_COUNT = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/tpg_in_if.sv -----
// Request channel carrying one grid cell and its end-of-grid flag.
`default_nettype none

interface tpg_in_if import tpg_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [CELL_BITS-1:0] cell_value;
    logic                 last_cell;

    modport source (output valid, output cell_value, output last_cell, input ready);
    modport sink   (input valid, input cell_value, input last_cell, output ready);

endinterface

`default_nettype wire

// ----- rtl/tpg_out_if.sv -----
// Request channel carrying one result: best combined sum and no-path flag.
`default_nettype none

interface tpg_out_if import tpg_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [SUM_OUT_BITS-1:0] best_sum;
    logic                    no_path;

    modport source (output valid, output best_sum, output no_path, input ready);
    modport sink   (input valid, input best_sum, input no_path, output ready);

endinterface

`default_nettype wire

// ----- rtl/two_path_grid_max_sum.sv -----
// Top level: grid loader and sequenced dynamic program for two disjoint paths.
`default_nettype none

// Grid cells arrive in row-major order, one request per cycle while no run is in
// progress, and are kept in a grid memory with one write port and one read port;
// the request flagged last_cell starts a run and no further cell is taken until the
// result has been handed to the output register. A run walks the anti-diagonals
// s = 1 .. rows+cols-2 and, within each step, every row pair (a, b) of the
// configured square, so it visits rows*rows*(rows+cols-2) states. Each state takes
// one read of the previous layer (two ports of the DP memory), then a single compare
// unit folds the four predecessor candidates in turn, and a write state adds both
// cell values and writes the current layer. The two grid reads of a state share the
// one grid read port; a 1 x 1 grid goes straight to the result with no DP step. The
// DP layers need no clearing: every entry of the square is rewritten at every step,
// and the first step reads a fixed start layer instead of memory. Row and column
// counts are taken from the registers when the run starts; 0 acts as 1 and values
// above the maximum act as the maximum. best_sum saturates.
module two_path_grid_max_sum import tpg_pkg::*; #(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COUNT_BITS-1:0]     cfg_data,
    tpg_in_if.sink                    cell_in,
    tpg_out_if.source                 result_out
);

    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int GA          = $clog2(STORE_DEPTH);
    localparam int RB          = $clog2(MAX_ROWS);
    localparam int CB          = $clog2(MAX_COLS);
    localparam int S_BITS      = $clog2(MAX_ROWS + MAX_COLS - 1);
    localparam int CW          = S_BITS + 1;
    localparam int SUM_BITS    = VALUE_BITS + 1 + $clog2(MAX_ROWS + MAX_COLS);
    localparam int ENTRY_BITS  = SUM_BITS + 1;
    localparam int DP_DEPTH    = 2 * (2 ** RB) * (2 ** RB);
    localparam int DA          = 1 + 2 * RB;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_CMP  = 5'b00100,
        ST_WR   = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    // Predecessor candidates of state (a, b)
    typedef enum logic [1:0] {
        CAND_STAY = 2'd0,   // (a, b)
        CAND_DIAG = 2'd1,   // (a-1, b-1)
        CAND_LEFT = 2'd2,   // (a, b-1)
        CAND_UP   = 2'd3    // (a-1, b)
    } cand_t;

    // Memories
    logic [VALUE_BITS-1:0] grid_mem [STORE_DEPTH];
    logic [ENTRY_BITS-1:0] dp_mem   [DP_DEPTH];

    // Control and datapath registers
    state_t                state_reg;
    cand_t                 cand_reg;
    logic [COUNT_BITS-1:0] row_count_reg;
    logic [COUNT_BITS-1:0] col_count_reg;
    logic [GA-1:0]         load_pos_reg;
    logic [RB-1:0]         rows_m1_reg;
    logic [CB-1:0]         cols_m1_reg;
    logic [S_BITS-1:0]     last_reg;
    logic [S_BITS-1:0]     s_reg;
    logic [RB-1:0]         a_reg;
    logic [RB-1:0]         b_reg;
    logic [GA-1:0]         addr_a_reg;
    logic [GA-1:0]         addr_b_reg;
    logic [VALUE_BITS-1:0] grid_q_reg;
    logic [VALUE_BITS-1:0] cell_a_reg;
    logic [ENTRY_BITS-1:0] q0_reg;
    logic [ENTRY_BITS-1:0] q1_reg;
    logic [ENTRY_BITS-1:0] left0_reg;
    logic [ENTRY_BITS-1:0] left1_reg;
    logic                  have_reg;
    logic [SUM_BITS-1:0]   best_reg;
    logic                  final_have_reg;
    logic [SUM_BITS-1:0]   final_sum_reg;
    logic                  out_valid_reg;
    logic [SUM_OUT_BITS-1:0] out_sum_reg;
    logic                  out_no_path_reg;

    // Combinational values
    logic                  in_fire;
    logic [RB:0]           rows_cl;
    logic [CB:0]           cols_cl;
    logic [S_BITS-1:0]     last_next;
    logic                  s_first;
    logic                  a_zero;
    logic                  b_zero;
    logic                  a_one;
    logic                  b_one;
    logic                  cand_ok;
    logic [SUM_BITS-1:0]   cand_val;
    logic                  take_next;
    logic [VALUE_BITS:0]   gain_next;
    logic [SUM_BITS-1:0]   sum_next;
    logic                  skip_next;
    logic                  ok_next;
    logic [CW-1:0]         s_w;
    logic [CW-1:0]         a_w;
    logic [CW-1:0]         b_w;
    logic [CW-1:0]         c_w;
    logic                  grid_re;
    logic [GA-1:0]         grid_raddr;
    logic [DA-1:0]         dp_raddr0;
    logic [DA-1:0]         dp_raddr1;
    logic [DA-1:0]         dp_waddr;
    logic                  dp_re;
    logic                  dp_we;
    logic                  out_load;
    logic [SUM_OUT_BITS-1:0] sat_sum;

    assign in_fire       = cell_in.valid && cell_in.ready;
    assign cell_in.ready = (state_reg == ST_IDLE);

    assign result_out.valid    = out_valid_reg;
    assign result_out.best_sum = out_sum_reg;
    assign result_out.no_path  = out_no_path_reg;

    // Clamp the configured counts at run start
    always_comb
    begin
        if (row_count_reg == '0)
            rows_cl = (RB+1)'(1);
        else if (32'(row_count_reg) > MAX_ROWS)
            rows_cl = (RB+1)'(MAX_ROWS);
        else
            rows_cl = (RB+1)'(row_count_reg);
        if (col_count_reg == '0)
            cols_cl = (CB+1)'(1);
        else if (32'(col_count_reg) > MAX_COLS)
            cols_cl = (CB+1)'(MAX_COLS);
        else
            cols_cl = (CB+1)'(col_count_reg);
        last_next = S_BITS'(rows_cl) + S_BITS'(cols_cl) - S_BITS'(2);
    end

    // Candidate selection for the shared compare unit
    assign s_first = (s_reg == S_BITS'(1));
    assign a_zero  = (a_reg == '0);
    assign b_zero  = (b_reg == '0);
    assign a_one   = (a_reg == RB'(1));
    assign b_one   = (b_reg == RB'(1));

    always_comb
    begin
        cand_ok  = 1'b0;
        cand_val = '0;
        case (cand_reg)
            CAND_STAY:
            begin
                cand_ok  = s_first ? (a_zero && b_zero) : q0_reg[SUM_BITS];
                cand_val = s_first ? '0 : q0_reg[SUM_BITS-1:0];
            end
            CAND_DIAG:
            begin
                cand_ok  = !a_zero && !b_zero &&
                           (s_first ? (a_one && b_one) : left1_reg[SUM_BITS]);
                cand_val = s_first ? '0 : left1_reg[SUM_BITS-1:0];
            end
            CAND_LEFT:
            begin
                cand_ok  = !b_zero && (s_first ? (a_zero && b_one) : left0_reg[SUM_BITS]);
                cand_val = s_first ? '0 : left0_reg[SUM_BITS-1:0];
            end
            CAND_UP:
            begin
                cand_ok  = !a_zero && (s_first ? (a_one && b_zero) : q1_reg[SUM_BITS]);
                cand_val = s_first ? '0 : q1_reg[SUM_BITS-1:0];
            end
            default:
            begin
                cand_ok  = 1'b0;
                cand_val = '0;
            end
        endcase
        take_next = cand_ok && (!have_reg || (cand_val > best_reg));
    end

    // State legality and the new sum
    assign s_w = CW'(s_reg);
    assign a_w = CW'(a_reg);
    assign b_w = CW'(b_reg);
    assign c_w = CW'(cols_m1_reg);

    always_comb
    begin
        skip_next = 1'b0;
        if ((a_reg == b_reg) && !((s_reg == last_reg) && (a_reg == rows_m1_reg)))
            skip_next = 1'b1;
        if ((a_w > s_w) || (b_w > s_w))
            skip_next = 1'b1;
        if ((s_w > a_w + c_w) || (s_w > b_w + c_w))
            skip_next = 1'b1;
        gain_next = (VALUE_BITS+1)'(cell_a_reg) + (VALUE_BITS+1)'(grid_q_reg);
        sum_next  = best_reg + SUM_BITS'(gain_next);
        ok_next   = have_reg && !skip_next;
    end

    // Memory port control
    assign grid_re    = (state_reg == ST_READ) ||
                        ((state_reg == ST_CMP) && (cand_reg == CAND_STAY));
    assign grid_raddr = (state_reg == ST_READ) ? addr_a_reg : addr_b_reg;
    assign dp_re      = (state_reg == ST_READ);
    assign dp_we      = (state_reg == ST_WR);
    assign dp_raddr0  = {~s_reg[0], a_reg, b_reg};
    assign dp_raddr1  = {~s_reg[0], a_reg - RB'(1), b_reg};
    assign dp_waddr   = {s_reg[0], a_reg, b_reg};

    // Result formatting
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || result_out.ready);
    assign sat_sum  = (32'(final_sum_reg) > 32'(SUM_OUT_MAX)) ? SUM_OUT_MAX
                                                              : SUM_OUT_BITS'(final_sum_reg);

    // Grid store: load port and sequencer read port
    always_ff @(posedge clk)
    begin
        if (in_fire)
            grid_mem[load_pos_reg] <= VALUE_BITS'(cell_in.cell_value);
        if (grid_re)
            grid_q_reg <= grid_mem[grid_raddr];
    end

    // DP layers: two read ports, one write port
    always_ff @(posedge clk)
    begin
        if (dp_we)
            dp_mem[dp_waddr] <= {ok_next, sum_next};
        if (dp_re)
        begin
            q0_reg <= dp_mem[dp_raddr0];
            q1_reg <= dp_mem[dp_raddr1];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= COUNT_BITS'(1);
            col_count_reg <= COUNT_BITS'(1);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_ROW_COUNT: row_count_reg <= cfg_data;
                CFG_COL_COUNT: col_count_reg <= cfg_data;
                default:       row_count_reg <= row_count_reg;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cand_reg        <= CAND_STAY;
            load_pos_reg    <= '0;
            rows_m1_reg     <= '0;
            cols_m1_reg     <= '0;
            last_reg        <= '0;
            s_reg           <= '0;
            a_reg           <= '0;
            b_reg           <= '0;
            addr_a_reg      <= '0;
            addr_b_reg      <= '0;
            cell_a_reg      <= '0;
            left0_reg       <= '0;
            left1_reg       <= '0;
            have_reg        <= 1'b0;
            best_reg        <= '0;
            final_have_reg  <= 1'b0;
            final_sum_reg   <= '0;
            out_valid_reg   <= 1'b0;
            out_sum_reg     <= '0;
            out_no_path_reg <= 1'b0;
        end
        else
        begin
            // A new result loaded in ST_DONE takes the place of the one leaving
            if (out_valid_reg && result_out.ready && !out_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (cell_in.last_cell)
                        begin
                            load_pos_reg   <= '0;
                            rows_m1_reg    <= RB'(rows_cl - (RB+1)'(1));
                            cols_m1_reg    <= CB'(cols_cl - (CB+1)'(1));
                            last_reg       <= last_next;
                            s_reg          <= S_BITS'(1);
                            a_reg          <= '0;
                            b_reg          <= '0;
                            addr_a_reg     <= GA'(1);
                            addr_b_reg     <= GA'(1);
                            final_have_reg <= 1'b1;
                            final_sum_reg  <= '0;
                            state_reg      <= (last_next == '0) ? ST_DONE : ST_READ;
                        end
                        else if (load_pos_reg == GA'(STORE_DEPTH - 1))
                            load_pos_reg <= '0;
                        else
                            load_pos_reg <= load_pos_reg + GA'(1);
                    end
                end
                ST_READ:
                begin
                    have_reg  <= 1'b0;
                    best_reg  <= '0;
                    cand_reg  <= CAND_STAY;
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    if (take_next)
                    begin
                        have_reg <= 1'b1;
                        best_reg <= cand_val;
                    end
                    case (cand_reg)
                        CAND_STAY:
                        begin
                            cell_a_reg <= grid_q_reg;
                            cand_reg   <= CAND_DIAG;
                        end
                        CAND_DIAG: cand_reg <= CAND_LEFT;
                        CAND_LEFT: cand_reg <= CAND_UP;
                        default:   state_reg <= ST_WR;
                    endcase
                end
                ST_WR:
                begin
                    // Row b-1 values of the next state are this state's reads
                    left0_reg <= q0_reg;
                    left1_reg <= q1_reg;
                    if ((a_reg == rows_m1_reg) && (b_reg == rows_m1_reg))
                    begin
                        final_have_reg <= ok_next;
                        final_sum_reg  <= sum_next;
                    end
                    if (b_reg != rows_m1_reg)
                    begin
                        b_reg      <= b_reg + RB'(1);
                        addr_b_reg <= addr_b_reg + GA'(cols_m1_reg);
                        state_reg  <= ST_READ;
                    end
                    else if (a_reg != rows_m1_reg)
                    begin
                        b_reg      <= '0;
                        addr_b_reg <= GA'(s_reg);
                        a_reg      <= a_reg + RB'(1);
                        addr_a_reg <= addr_a_reg + GA'(cols_m1_reg);
                        state_reg  <= ST_READ;
                    end
                    else if (s_reg != last_reg)
                    begin
                        s_reg      <= s_reg + S_BITS'(1);
                        a_reg      <= '0;
                        b_reg      <= '0;
                        addr_a_reg <= GA'(s_reg) + GA'(1);
                        addr_b_reg <= GA'(s_reg) + GA'(1);
                        state_reg  <= ST_READ;
                    end
                    else
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_sum_reg     <= final_have_reg ? sat_sum : '0;
                        out_no_path_reg <= !final_have_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_two_path_grid_max_sum.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the two-path grid maximum-sum block.
module tb_two_path_grid_max_sum import tpg_pkg::*;;

    localparam int     MAX_ROWS      = MAX_ROWS_DEF;
    localparam int     MAX_COLS      = MAX_COLS_DEF;
    localparam int     STORE_DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int     CLK_HALF      = 10;
    localparam int     RESET_CYCLES  = 7;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     HOLD_CYCLES   = 3000;
    localparam int     RANDOM_CELLS  = 800;
    // slowest pass is dominated by one 64-row run
    localparam longint LIMIT_CYCLES  = 10_000_000;

    typedef struct packed {
        logic [SUM_OUT_BITS-1:0] sum;
        logic                    no_path;
    } result_t;

    // one row of the directed plan: either a resize or one cell request
    typedef struct packed {
        logic                    resize;
        logic [COUNT_BITS-1:0]   rows;
        logic [COUNT_BITS-1:0]   cols;
        logic [CELL_BITS-1:0]    value;
        logic                    last;
        logic                    typed;
        logic [SUM_OUT_BITS-1:0] sum;
        logic                    no_path;
    } plan_row_t;

    localparam int PLAN_LEN = 26;

    plan_row_t plan [PLAN_LEN] = '{
        // 1 x 1 grid straight after reset: no step taken
        '{1'b0, 7'd0, 7'd0, 8'hff, 1'b1, 1'b1, 17'd0,    1'b0},
        // zero rows acts as one; two cells in a row
        '{1'b1, 7'd0, 7'd2, 8'h00, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'h00, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'hff, 1'b1, 1'b1, 17'd510,  1'b0},
        // single row of three: paths must share a cell
        '{1'b1, 7'd1, 7'd3, 8'h00, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'h01, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'h02, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'h03, 1'b1, 1'b1, 17'd0,    1'b1},
        // 2 x 2 all full scale
        '{1'b1, 7'd2, 7'd2, 8'h00, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'hff, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'hff, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'hff, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'hff, 1'b1, 1'b1, 17'd1020, 1'b0},
        // zero columns acts as one: two cells in a column
        '{1'b1, 7'd2, 7'd0, 8'h00, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'h07, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'h09, 1'b1, 1'b1, 17'd18,   1'b0},
        // 3 x 3 with mixed bit patterns, predicted
        '{1'b1, 7'd3, 7'd3, 8'h00, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'h00, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'hff, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'h55, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'haa, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'h01, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'h80, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'h7f, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'hfe, 1'b0, 1'b0, 17'd0,    1'b0},
        '{1'b0, 7'd0, 7'd0, 8'h33, 1'b1, 1'b0, 17'd0,    1'b0}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [COUNT_BITS-1:0]     cfg_data;

    tpg_in_if  cell_if ();
    tpg_out_if res_if ();

    two_path_grid_max_sum DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cell_in      (cell_if),
        .result_out   (res_if)
    );

    // predictor state: grid copy, load pointer, size registers, DP layers
    logic [CELL_BITS-1:0]  grid_mem      [STORE_DEPTH];
    bit                    cell_written  [STORE_DEPTH];
    int                    load_addr;
    logic [COUNT_BITS-1:0] rows_reg;
    logic [COUNT_BITS-1:0] cols_reg;
    int unsigned           layer_sum     [2][MAX_ROWS][MAX_ROWS];
    bit                    layer_ok      [2][MAX_ROWS][MAX_ROWS];

    result_t pending_sums [$];
    int      errors;
    bit      quiet;
    bit      hold_req;
    longint  cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // mostly short idle gaps, now and then a long one
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 90) return $urandom_range(1, 3);
        if (k < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [CELL_BITS-1:0] rand_cell();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return '0;
        if (k == 1) return '1;
        return CELL_BITS'($urandom);
    endfunction

    // best combined value of two disjoint monotone paths over the loaded grid
    function automatic result_t predict_best_pair();
        int          rows;
        int          cols;
        int          last;
        int          cur;
        int          prv;
        int unsigned best;
        bit          have;
        result_t     r;
        rows = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg));
        cols = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg));
        last = rows + cols - 2;
        cur  = 0;
        for (int a = 0; a < rows; a++)
            for (int b = 0; b < rows; b++)
                layer_ok[0][a][b] = 1'b0;
        layer_ok[0][0][0]  = 1'b1;
        layer_sum[0][0][0] = 0;
        for (int s = 1; s <= last; s++)
        begin
            prv = cur;
            cur = 1 - cur;
            for (int a = 0; a < rows; a++)
            begin
                for (int b = 0; b < rows; b++)
                begin
                    layer_ok[cur][a][b] = 1'b0;
                    // shared cells only allowed at the final corner
                    if (a == b && !(s == last && a == rows - 1)) continue;
                    if (a > s || b > s || s - a >= cols || s - b >= cols) continue;
                    have = 1'b0;
                    best = 0;
                    if (layer_ok[prv][a][b])
                    begin
                        best = layer_sum[prv][a][b];
                        have = 1'b1;
                    end
                    if (a > 0 && b > 0 && layer_ok[prv][a-1][b-1] &&
                        (!have || layer_sum[prv][a-1][b-1] > best))
                    begin
                        best = layer_sum[prv][a-1][b-1];
                        have = 1'b1;
                    end
                    if (b > 0 && layer_ok[prv][a][b-1] &&
                        (!have || layer_sum[prv][a][b-1] > best))
                    begin
                        best = layer_sum[prv][a][b-1];
                        have = 1'b1;
                    end
                    if (a > 0 && layer_ok[prv][a-1][b] &&
                        (!have || layer_sum[prv][a-1][b] > best))
                    begin
                        best = layer_sum[prv][a-1][b];
                        have = 1'b1;
                    end
                    if (!have) continue;
                    layer_sum[cur][a][b] = best + grid_mem[a * cols + s - a]
                                                + grid_mem[b * cols + s - b];
                    layer_ok[cur][a][b]  = 1'b1;
                end
            end
        end
        if (!layer_ok[cur][rows-1][rows-1])
        begin
            r.sum     = '0;
            r.no_path = 1'b1;
        end
        else
        begin
            best      = layer_sum[cur][rows-1][rows-1];
            r.sum     = (best > SUM_OUT_MAX) ? SUM_OUT_MAX : best[SUM_OUT_BITS-1:0];
            r.no_path = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    // offer one cell request; on acceptance update the grid copy, predict on the last cell
    task automatic send_cell(input logic [CELL_BITS-1:0] v, input logic last,
                             input logic typed, input result_t typed_res);
        int      gap;
        result_t guess;
        gap = quiet ? 0 : gap_len();
        if (gap > 0)
        begin
            cell_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cell_if.valid      <= 1'b1;
        cell_if.cell_value <= v;
        cell_if.last_cell  <= last;
        @(posedge clk);
        while (!cell_if.ready) @(posedge clk);
        grid_mem[load_addr]     = v;
        cell_written[load_addr] = 1'b1;
        load_addr = (load_addr + 1 >= STORE_DEPTH) ? 0 : load_addr + 1;
        if (last)
        begin
            guess     = predict_best_pair();
            load_addr = 0;
            pending_sums.push_back(typed ? typed_res : guess);
        end
    endtask

    task automatic send_grid(input int ncells);
        for (int i = 0; i < ncells; i++)
            send_cell(rand_cell(), i == ncells - 1, 1'b0, '0);
    endtask

    // both size registers, back to back
    task automatic set_grid_size(input logic [COUNT_BITS-1:0] r,
                                 input logic [COUNT_BITS-1:0] c);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_ROW_COUNT;
        cfg_data     <= r;
        @(posedge clk);
        cfg_index    <= CFG_COL_COUNT;
        cfg_data     <= c;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        rows_reg = r;
        cols_reg = c;
    endtask

    // stop offering and wait for every pending result, then let the block settle
    task automatic wait_idle();
        cell_if.valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result receiver: random stalls, a long hold-off on request
    initial
    begin
        int g;
        res_if.ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (quiet || $urandom_range(0, 3) != 0)
            begin
                res_if.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                g = gap_len();
                res_if.ready <= 1'b0;
                repeat (g + 1) @(posedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_sums.size() == 0)
                report_mismatch("result with no request pending", res_if.best_sum, 0);
            else
            begin
                want = pending_sums.pop_front();
                if (res_if.best_sum !== want.sum)
                    report_mismatch("best_sum", res_if.best_sum, want.sum);
                if (res_if.no_path !== want.no_path)
                    report_mismatch("no_path", res_if.no_path, want.no_path);
            end
        end
    end

    // watchdog
    initial
    begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // stimulus
    initial
    begin
        int      random_cells;
        int      phase;
        int      r;
        int      c;
        int      n;
        int      k;
        int      ncells;
        bit      ok;
        logic [COUNT_BITS-1:0] wr;
        logic [COUNT_BITS-1:0] wc;
        result_t typed_res;

        rst_n              = 1'b0;
        cfg_write_en       = 1'b0;
        cfg_index          = CFG_ROW_COUNT;
        cfg_data           = '0;
        cell_if.valid      = 1'b0;
        cell_if.cell_value = '0;
        cell_if.last_cell  = 1'b0;
        errors             = 0;
        quiet              = 1'b0;
        hold_req           = 1'b0;
        load_addr          = 0;
        rows_reg           = 1;
        cols_reg           = 1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan
        foreach (plan[i])
        begin
            if (plan[i].resize)
            begin
                wait_idle();
                set_grid_size(plan[i].rows, plan[i].cols);
            end
            else
            begin
                typed_res.sum     = plan[i].sum;
                typed_res.no_path = plan[i].no_path;
                send_cell(plan[i].value, plan[i].last, plan[i].typed, typed_res);
            end
        end

        // random phases, special ones interleaved
        random_cells = 0;
        phase        = 0;
        while (random_cells < RANDOM_CELLS)
        begin
            phase++;
            wait_idle();
            if (phase == 3)
            begin
                // receiver holds off while 2 x 2 grids keep coming
                set_grid_size(2, 2);
                hold_req = 1'b1;
                repeat (12) send_grid(4);
            end
            else if (phase == 6)
            begin
                // widest rows; column count above the maximum
                set_grid_size(1, 127);
                send_grid(MAX_COLS);
                wait_idle();
                set_grid_size(2, 64);
                send_grid(2 * MAX_COLS);
                wait_idle();
                set_grid_size(3, 64);
                send_grid(3 * MAX_COLS);
            end
            else if (phase == 9)
            begin
                // load pointer wraps past the end of the store; no idling
                quiet = 1'b1;
                set_grid_size(2, 2);
                for (int i = 0; i < STORE_DEPTH + 3; i++)
                    send_cell(rand_cell(), 1'b0, 1'b0, '0);
                send_cell(rand_cell(), 1'b1, 1'b0, '0);
                wait_idle();
                quiet = 1'b0;
            end
            else if (phase == 12)
            begin
                set_grid_size(16, 16);
                send_grid(256);
                wait_idle();
                set_grid_size(12, 20);
                send_grid(240);
            end
            else
            begin
                quiet = (phase % 5 == 0);
                k = $urandom_range(0, 9);
                r = (k < 6) ? $urandom_range(1, 3) : ((k < 9) ? $urandom_range(4, 6)
                                                              : $urandom_range(7, 10));
                k = $urandom_range(0, 9);
                c = (k < 6) ? $urandom_range(1, 4) : ((k < 9) ? $urandom_range(5, 8)
                                                              : $urandom_range(9, 16));
                wr = COUNT_BITS'(r);
                wc = COUNT_BITS'(c);
                if (r == 1 && $urandom_range(0, 3) == 0) wr = '0;
                if (c == 1 && $urandom_range(0, 3) == 0) wc = '0;
                set_grid_size(wr, wc);
                n = r * c;
                repeat ($urandom_range(3, 8))
                begin
                    k      = $urandom_range(0, 9);
                    ncells = n;
                    if (k == 0)
                        ncells = n + $urandom_range(1, 5);
                    else if (k == 1 && n > 1)
                    begin
                        // short grid: tail comes from earlier loads, if written
                        ncells = $urandom_range(1, n - 1);
                        ok     = 1'b1;
                        for (int i = ncells; i < n; i++)
                            if (!cell_written[i]) ok = 1'b0;
                        if (!ok) ncells = n;
                    end
                    send_grid(ncells);
                    random_cells += ncells;
                end
                if (quiet)
                begin
                    wait_idle();
                    quiet = 1'b0;
                end
            end
        end

        // tallest grid once: row count above the maximum, zero columns
        wait_idle();
        set_grid_size(127, 0);
        send_grid(MAX_ROWS);

        wait_idle();
        if (errors == 0 && pending_sums.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
